// ===== rtl/assert_macros.svh =====
// assertion macros used by the merge top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(cond))) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/istm_pkg.sv =====
// shared constants, codes and types of the imu stereo timestamp merge
`default_nettype none

package istm_pkg;

  localparam int TimeBits      = 32;
  localparam int HandleBits    = 16;
  localparam int OutHandleBits = 16;
  localparam int KindBits      = 3;
  localparam int StatusBits    = 2;

  localparam int ImuDepth    = 256;
  localparam int ImageDepth  = 16;
  localparam int ImuAw       = $clog2(ImuDepth);
  localparam int ImuFillBits = ImuAw + 1;
  localparam int ImgAw       = $clog2(ImageDepth);
  localparam int ImgFillBits = ImgAw + 1;

  localparam logic [KindBits-1:0] KindPushImu   = 3'd0;
  localparam logic [KindBits-1:0] KindPushLeft  = 3'd1;
  localparam logic [KindBits-1:0] KindPushRight = 3'd2;
  localparam logic [KindBits-1:0] KindPop       = 3'd3;
  localparam logic [KindBits-1:0] KindClear     = 3'd4;

  localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
  localparam logic [StatusBits-1:0] StatusOrder = 2'd1;
  localparam logic [StatusBits-1:0] StatusFull  = 2'd2;
  localparam logic [StatusBits-1:0] StatusEmpty = 2'd3;

  localparam logic [TimeBits-1:0] ToleranceReset = 32'd5000;

  typedef struct packed {
    logic [TimeBits-1:0]   time_stamp;
    logic [HandleBits-1:0] handle;
  } istm_entry_t;

  localparam int EntryBits = $bits(istm_entry_t);

  typedef struct packed {
    logic none;
    logic imu;
    logic left;
    logic right;
  } istm_pick_t;

  typedef struct packed {
    logic [StatusBits-1:0]    status;
    logic                     imu_valid;
    logic [TimeBits-1:0]      imu_time;
    logic [OutHandleBits-1:0] imu_handle;
    logic                     left_valid;
    logic [TimeBits-1:0]      left_time;
    logic [OutHandleBits-1:0] left_handle;
    logic                     right_valid;
    logic [TimeBits-1:0]      right_time;
    logic [OutHandleBits-1:0] right_handle;
  } istm_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/istm_if.sv =====
// request and result channel interfaces
`default_nettype none

interface istm_req_if;
  logic                             valid;
  logic                             ready;
  logic [istm_pkg::KindBits-1:0]    kind;
  logic [istm_pkg::TimeBits-1:0]    time_stamp;
  logic [istm_pkg::OutHandleBits-1:0] payload_handle;

  modport source (output valid, output kind, output time_stamp, output payload_handle,
                  input ready);
  modport sink (input valid, input kind, input time_stamp, input payload_handle,
                output ready);
endinterface

interface istm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [istm_pkg::StatusBits-1:0]     status;
  logic                                imu_valid;
  logic [istm_pkg::TimeBits-1:0]       imu_time;
  logic [istm_pkg::OutHandleBits-1:0]  imu_handle;
  logic                                left_valid;
  logic [istm_pkg::TimeBits-1:0]       left_time;
  logic [istm_pkg::OutHandleBits-1:0]  left_handle;
  logic                                right_valid;
  logic [istm_pkg::TimeBits-1:0]       right_time;
  logic [istm_pkg::OutHandleBits-1:0]  right_handle;

  modport source (output valid, output status,
                  output imu_valid, output imu_time, output imu_handle,
                  output left_valid, output left_time, output left_handle,
                  output right_valid, output right_time, output right_handle,
                  input ready);
  modport sink (input valid, input status,
                input imu_valid, input imu_time, input imu_handle,
                input left_valid, input left_time, input left_handle,
                input right_valid, input right_time, input right_handle,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/istm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module istm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/istm_pick.sv =====
// chooses which queue heads a pop hands out
`default_nettype none

module istm_pick (
  input  logic                          imu_empty_i,
  input  logic                          left_empty_i,
  input  logic                          right_empty_i,
  input  logic [istm_pkg::TimeBits-1:0] imu_time_i,
  input  logic [istm_pkg::TimeBits-1:0] left_time_i,
  input  logic [istm_pkg::TimeBits-1:0] right_time_i,
  input  logic [istm_pkg::TimeBits-1:0] tolerance_i,
  output istm_pkg::istm_pick_t          pick_o
);

  import istm_pkg::*;

  logic                imu_wins;
  logic                pair;
  logic [TimeBits-1:0] gap;

  always_comb begin
    gap = (left_time_i > right_time_i) ? (left_time_i - right_time_i)
                                       : (right_time_i - left_time_i);
    pair = gap < tolerance_i;

    imu_wins = 1'b0;
    if (!imu_empty_i) begin
      if (left_empty_i && right_empty_i) begin
        imu_wins = 1'b1;
      end else if (left_empty_i) begin
        imu_wins = imu_time_i < right_time_i;
      end else if (right_empty_i) begin
        imu_wins = imu_time_i < left_time_i;
      end else begin
        imu_wins = (imu_time_i <= left_time_i) || (imu_time_i <= right_time_i);
      end
    end

    pick_o = '0;
    if (imu_empty_i && left_empty_i && right_empty_i) begin
      pick_o.none = 1'b1;
    end else if (imu_wins) begin
      pick_o.imu = 1'b1;
    end else if (left_empty_i) begin
      pick_o.right = 1'b1;
    end else if (right_empty_i) begin
      pick_o.left = 1'b1;
    end else if (pair) begin
      pick_o.left  = 1'b1;
      pick_o.right = 1'b1;
    end else if (left_time_i < right_time_i) begin
      pick_o.left = 1'b1;
    end else begin
      pick_o.right = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_stereo_timestamp_merge.sv =====
// merges timestamped imu, left and right frame queues into one ordered stream
//
// req_i carries commands (push imu, push left, push right, pop, clear) with a
// time stamp and a payload handle; rsp_o returns exactly one result per
// command. both are valid/ready channels, a transfer happens when both are high.
// cfg_we_i writes the stereo pairing tolerance from cfg_data_i (reset 5000 us).
// pushes, clears and unused codes: the result is registered and appears in the
// cycle after the transfer. in a pop, the head entries are first read from the
// three queue rams (registered read), then the pick logic chooses and the
// pointers move. no command is accepted while a pop is still at work.
// after reset all queues are empty and no result is pending; the ram contents
// are left as they are, the fill counts mark which entries are live.
// when the receiver stalls, the pending result holds on rsp_o and req_i.ready
// stays low until it is taken.
`default_nettype none
`include "assert_macros.svh"

module imu_stereo_timestamp_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [istm_pkg::TimeBits-1:0] cfg_data_i,
  istm_req_if.sink                      req_i,
  istm_rsp_if.source                    rsp_o
);

  import istm_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StPick = 1'b1;

  logic state_q, state_d;
  logic [TimeBits-1:0] tol_q;

  logic [ImuAw-1:0]       imu_head_q, imu_head_d;
  logic [ImuFillBits-1:0] imu_fill_q, imu_fill_d;
  logic [TimeBits-1:0]    imu_newest_q, imu_newest_d;
  logic [ImgAw-1:0]       left_head_q, left_head_d;
  logic [ImgFillBits-1:0] left_fill_q, left_fill_d;
  logic [TimeBits-1:0]    left_newest_q, left_newest_d;
  logic [ImgAw-1:0]       right_head_q, right_head_d;
  logic [ImgFillBits-1:0] right_fill_q, right_fill_d;
  logic [TimeBits-1:0]    right_newest_q, right_newest_d;

  logic      rsp_valid_q, rsp_valid_d;
  istm_rsp_t rsp_q, rsp_d;

  logic                  req_fire;
  logic [StatusBits-1:0] push_status;
  logic                  imu_we, left_we, right_we;
  logic [ImuAw-1:0]      imu_waddr;
  logic [ImgAw-1:0]      left_waddr, right_waddr;
  istm_entry_t           wr_entry;
  istm_entry_t           imu_head_e, left_head_e, right_head_e;
  istm_pick_t            pick;

  assign req_i.ready = (state_q == StIdle) && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign wr_entry.time_stamp = req_i.time_stamp;
  assign wr_entry.handle     = req_i.payload_handle[HandleBits-1:0];

  assign imu_waddr   = imu_head_q + imu_fill_q[ImuAw-1:0];
  assign left_waddr  = left_head_q + left_fill_q[ImgAw-1:0];
  assign right_waddr = right_head_q + right_fill_q[ImgAw-1:0];

  always_comb begin
    push_status = StatusOk;
    case (req_i.kind)
      KindPushImu: begin
        if ((imu_fill_q != '0) && (imu_newest_q > req_i.time_stamp)) begin
          push_status = StatusOrder;
        end else if (imu_fill_q == ImuFillBits'(ImuDepth)) begin
          push_status = StatusFull;
        end
      end
      KindPushLeft: begin
        if ((left_fill_q != '0) && (left_newest_q > req_i.time_stamp)) begin
          push_status = StatusOrder;
        end else if (left_fill_q == ImgFillBits'(ImageDepth)) begin
          push_status = StatusFull;
        end
      end
      KindPushRight: begin
        if ((right_fill_q != '0) && (right_newest_q > req_i.time_stamp)) begin
          push_status = StatusOrder;
        end else if (right_fill_q == ImgFillBits'(ImageDepth)) begin
          push_status = StatusFull;
        end
      end
      default: push_status = StatusOk;
    endcase
  end

  assign imu_we   = req_fire && (req_i.kind == KindPushImu) && (push_status == StatusOk);
  assign left_we  = req_fire && (req_i.kind == KindPushLeft) && (push_status == StatusOk);
  assign right_we = req_fire && (req_i.kind == KindPushRight) && (push_status == StatusOk);

  // head entries are read every cycle at the current head pointers
  istm_ram #(.Width(EntryBits), .Depth(ImuDepth)) u_imu_ram (
    .clk_i   (clk_i),
    .we_i    (imu_we),
    .waddr_i (imu_waddr),
    .wdata_i (wr_entry),
    .raddr_i (imu_head_q),
    .rdata_o (imu_head_e)
  );

  istm_ram #(.Width(EntryBits), .Depth(ImageDepth)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (wr_entry),
    .raddr_i (left_head_q),
    .rdata_o (left_head_e)
  );

  istm_ram #(.Width(EntryBits), .Depth(ImageDepth)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (wr_entry),
    .raddr_i (right_head_q),
    .rdata_o (right_head_e)
  );

  istm_pick u_pick (
    .imu_empty_i   (imu_fill_q == '0),
    .left_empty_i  (left_fill_q == '0),
    .right_empty_i (right_fill_q == '0),
    .imu_time_i    (imu_head_e.time_stamp),
    .left_time_i   (left_head_e.time_stamp),
    .right_time_i  (right_head_e.time_stamp),
    .tolerance_i   (tol_q),
    .pick_o        (pick)
  );

  always_comb begin
    state_d        = state_q;
    imu_head_d     = imu_head_q;
    imu_fill_d     = imu_fill_q;
    imu_newest_d   = imu_newest_q;
    left_head_d    = left_head_q;
    left_fill_d    = left_fill_q;
    left_newest_d  = left_newest_q;
    right_head_d   = right_head_q;
    right_fill_d   = right_fill_q;
    right_newest_d = right_newest_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    rsp_d          = rsp_q;

    if (req_fire) begin
      if (imu_we) begin
        imu_fill_d   = imu_fill_q + 1'b1;
        imu_newest_d = req_i.time_stamp;
      end
      if (left_we) begin
        left_fill_d   = left_fill_q + 1'b1;
        left_newest_d = req_i.time_stamp;
      end
      if (right_we) begin
        right_fill_d   = right_fill_q + 1'b1;
        right_newest_d = req_i.time_stamp;
      end
      if (req_i.kind == KindClear) begin
        imu_head_d     = '0;
        imu_fill_d     = '0;
        imu_newest_d   = '0;
        left_head_d    = '0;
        left_fill_d    = '0;
        left_newest_d  = '0;
        right_head_d   = '0;
        right_fill_d   = '0;
        right_newest_d = '0;
      end
      if (req_i.kind == KindPop) begin
        state_d = StPick;
      end else begin
        rsp_valid_d  = 1'b1;
        rsp_d        = '0;
        rsp_d.status = push_status;
      end
    end

    if (state_q == StPick) begin
      state_d      = StIdle;
      rsp_valid_d  = 1'b1;
      rsp_d        = '0;
      rsp_d.status = pick.none ? StatusEmpty : StatusOk;
      if (pick.imu) begin
        imu_head_d       = imu_head_q + 1'b1;
        imu_fill_d       = imu_fill_q - 1'b1;
        rsp_d.imu_valid  = 1'b1;
        rsp_d.imu_time   = imu_head_e.time_stamp;
        rsp_d.imu_handle = imu_head_e.handle;
      end
      if (pick.left) begin
        left_head_d       = left_head_q + 1'b1;
        left_fill_d       = left_fill_q - 1'b1;
        rsp_d.left_valid  = 1'b1;
        rsp_d.left_time   = left_head_e.time_stamp;
        rsp_d.left_handle = left_head_e.handle;
      end
      if (pick.right) begin
        right_head_d       = right_head_q + 1'b1;
        right_fill_d       = right_fill_q - 1'b1;
        rsp_d.right_valid  = 1'b1;
        rsp_d.right_time   = right_head_e.time_stamp;
        rsp_d.right_handle = right_head_e.handle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      tol_q          <= ToleranceReset;
      imu_head_q     <= '0;
      imu_fill_q     <= '0;
      imu_newest_q   <= '0;
      left_head_q    <= '0;
      left_fill_q    <= '0;
      left_newest_q  <= '0;
      right_head_q   <= '0;
      right_fill_q   <= '0;
      right_newest_q <= '0;
      rsp_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      imu_head_q     <= imu_head_d;
      imu_fill_q     <= imu_fill_d;
      imu_newest_q   <= imu_newest_d;
      left_head_q    <= left_head_d;
      left_fill_q    <= left_fill_d;
      left_newest_q  <= left_newest_d;
      right_head_q   <= right_head_d;
      right_fill_q   <= right_fill_d;
      right_newest_q <= right_newest_d;
      rsp_valid_q    <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.imu_valid    = rsp_q.imu_valid;
  assign rsp_o.imu_time     = rsp_q.imu_time;
  assign rsp_o.imu_handle   = rsp_q.imu_handle;
  assign rsp_o.left_valid   = rsp_q.left_valid;
  assign rsp_o.left_time    = rsp_q.left_time;
  assign rsp_o.left_handle  = rsp_q.left_handle;
  assign rsp_o.right_valid  = rsp_q.right_valid;
  assign rsp_o.right_time   = rsp_q.right_time;
  assign rsp_o.right_handle = rsp_q.right_handle;

  `ASSERT_AT(a_imu_fill_range, clk_i, rst_ni, imu_fill_q <= ImuFillBits'(ImuDepth))
  `ASSERT_AT(a_left_fill_range, clk_i, rst_ni, left_fill_q <= ImgFillBits'(ImageDepth))
  `ASSERT_AT(a_right_fill_range, clk_i, rst_ni, right_fill_q <= ImgFillBits'(ImageDepth))
  `ASSERT_AT(a_pick_one_cycle, clk_i, rst_ni, (state_q == StPick) |=> (state_q == StIdle))
  `ASSERT_AT(a_pick_slot_free, clk_i, rst_ni, (state_q == StPick) |-> !rsp_valid_q)
  `ASSERT_NEVER(a_imu_not_with_image, clk_i, rst_ni,
                rsp_valid_q && rsp_q.imu_valid && (rsp_q.left_valid || rsp_q.right_valid))

endmodule

`default_nettype wire

// ===== bench/tb_imu_stereo_timestamp_merge.sv =====
// testbench of the imu stereo timestamp merge: directed and random commands, result checking
module tb_imu_stereo_timestamp_merge;
  import istm_pkg::*;

  localparam int QImu = 0;
  localparam int QLeft = 1;
  localparam int QRight = 2;
  localparam logic [KindBits-1:0] KindFirstUnused = 3'd5;
  localparam logic [KindBits-1:0] KindLastUnused = 3'd7;
  localparam int CycleLimit = 500000;
  localparam int DrainLimit = 5000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TimeBits-1:0] cfg_data_i;

  istm_req_if req_bus ();
  istm_rsp_if rsp_bus ();

  imu_stereo_timestamp_merge uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // predictor state
  istm_entry_t sensor_q[3][$];
  logic [TimeBits-1:0] tolerance_us;
  istm_rsp_t outcomes_due[$];

  // stimulus control
  logic [KindBits-1:0] push_kind[3];
  logic [TimeBits-1:0] stamp[3];
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int fail_count;
  int cycle_count;
  istm_rsp_t got;
  istm_rsp_t want;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_imu_stereo_timestamp_merge failed");
      $finish;
    end
  end

  // receiver with random stalls and long hold-offs
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_bus.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_bus.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic string rsp_text(input istm_rsp_t r);
    return $sformatf("st=%0d imu=%b/%h/%h left=%b/%h/%h right=%b/%h/%h", r.status,
                     r.imu_valid, r.imu_time, r.imu_handle, r.left_valid, r.left_time,
                     r.left_handle, r.right_valid, r.right_time, r.right_handle);
  endfunction

  task automatic report_failure(input string what, input istm_rsp_t exp_r, input istm_rsp_t act_r);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      $display("  expected %s", rsp_text(exp_r));
      $display("  actual   %s", rsp_text(act_r));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = '{rsp_bus.status, rsp_bus.imu_valid, rsp_bus.imu_time, rsp_bus.imu_handle,
              rsp_bus.left_valid, rsp_bus.left_time, rsp_bus.left_handle,
              rsp_bus.right_valid, rsp_bus.right_time, rsp_bus.right_handle};
      if (outcomes_due.size() == 0) begin
        report_failure("result with nothing pending", '0, got);
      end else begin
        want = outcomes_due[0];
        outcomes_due.delete(0);
        if (got.status !== want.status || got.imu_valid !== want.imu_valid ||
            got.imu_time !== want.imu_time || got.imu_handle !== want.imu_handle ||
            got.left_valid !== want.left_valid || got.left_time !== want.left_time ||
            got.left_handle !== want.left_handle || got.right_valid !== want.right_valid ||
            got.right_time !== want.right_time || got.right_handle !== want.right_handle) begin
          report_failure("wrong result field", want, got);
        end
      end
    end
  end

  function automatic logic [StatusBits-1:0] push_entry(input int qi, input logic [TimeBits-1:0] ts,
                                                       input logic [HandleBits-1:0] hd);
    int cap;
    int n;
    cap = (qi == QImu) ? ImuDepth : ImageDepth;
    n = sensor_q[qi].size();
    if (n != 0 && sensor_q[qi][n-1].time_stamp > ts) return StatusOrder;
    if (n >= cap) return StatusFull;
    sensor_q[qi].push_back({ts, hd});
    return StatusOk;
  endfunction

  function automatic void take_head(input int qi, inout istm_rsp_t r);
    istm_entry_t e;
    e = sensor_q[qi][0];
    sensor_q[qi].delete(0);
    case (qi)
      QImu: begin
        r.imu_valid = 1'b1;
        r.imu_time = e.time_stamp;
        r.imu_handle = e.handle;
      end
      QLeft: begin
        r.left_valid = 1'b1;
        r.left_time = e.time_stamp;
        r.left_handle = e.handle;
      end
      default: begin
        r.right_valid = 1'b1;
        r.right_time = e.time_stamp;
        r.right_handle = e.handle;
      end
    endcase
  endfunction

  function automatic void take_frames(inout istm_rsp_t r);
    logic [TimeBits-1:0] lt;
    logic [TimeBits-1:0] rt;
    logic [TimeBits-1:0] gap;
    lt = sensor_q[QLeft][0].time_stamp;
    rt = sensor_q[QRight][0].time_stamp;
    gap = (lt > rt) ? lt - rt : rt - lt;
    if (gap < tolerance_us) begin
      take_head(QLeft, r);
      take_head(QRight, r);
    end else if (lt < rt) begin
      take_head(QLeft, r);
    end else begin
      take_head(QRight, r);
    end
  endfunction

  function automatic istm_rsp_t merge_outcome(input logic [KindBits-1:0] kind,
                                              input logic [TimeBits-1:0] ts,
                                              input logic [HandleBits-1:0] hd);
    istm_rsp_t r;
    logic ie;
    logic le;
    logic re;
    logic [TimeBits-1:0] it;
    logic [TimeBits-1:0] lt;
    logic [TimeBits-1:0] rt;
    r = '0;
    case (kind)
      KindPushImu: r.status = push_entry(QImu, ts, hd);
      KindPushLeft: r.status = push_entry(QLeft, ts, hd);
      KindPushRight: r.status = push_entry(QRight, ts, hd);
      KindPop: begin
        ie = sensor_q[QImu].size() == 0;
        le = sensor_q[QLeft].size() == 0;
        re = sensor_q[QRight].size() == 0;
        it = ie ? '0 : sensor_q[QImu][0].time_stamp;
        lt = le ? '0 : sensor_q[QLeft][0].time_stamp;
        rt = re ? '0 : sensor_q[QRight][0].time_stamp;
        if (ie && le && re) r.status = StatusEmpty;
        else if (ie) begin
          if (le) take_head(QRight, r);
          else if (re) take_head(QLeft, r);
          else take_frames(r);
        end else if (le && re) take_head(QImu, r);
        else if (le) begin
          if (it < rt) take_head(QImu, r);
          else take_head(QRight, r);
        end else if (re) begin
          if (it < lt) take_head(QImu, r);
          else take_head(QLeft, r);
        end else if (it <= lt || it <= rt) take_head(QImu, r);
        else take_frames(r);
      end
      KindClear: begin
        sensor_q[QImu].delete();
        sensor_q[QLeft].delete();
        sensor_q[QRight].delete();
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [KindBits-1:0] kind, input logic [TimeBits-1:0] ts,
                           input logic [HandleBits-1:0] hd);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid = 1'b1;
    req_bus.kind = kind;
    req_bus.time_stamp = ts;
    req_bus.payload_handle = hd;
    do begin
      @(posedge clk_i);
    end while (req_bus.ready !== 1'b1);
    outcomes_due.push_back(merge_outcome(kind, ts, hd));
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (outcomes_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [TimeBits-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tolerance_us = value;
  endtask

  task automatic pop_one();
    send_item(KindPop, $urandom(), HandleBits'($urandom_range(65535)));
  endtask

  task automatic reseed_stamps();
    logic [TimeBits-1:0] base;
    base = $urandom();
    stamp[QImu] = base;
    stamp[QLeft] = base;
    stamp[QRight] = base;
  endtask

  // mostly ordered pushes and pops, with some noise and broken ordering
  task automatic run_random(input int count);
    int done;
    int roll;
    int qi;
    logic [KindBits-1:0] kind;
    logic [TimeBits-1:0] ts;
    done = 0;
    send_item(KindClear, $urandom(), HandleBits'($urandom_range(65535)));
    reseed_stamps();
    while (done < count) begin
      roll = $urandom_range(99);
      ts = $urandom();
      if (roll < 58) begin
        qi = (roll < 30) ? QImu : (roll < 44) ? QLeft : QRight;
        stamp[qi] = stamp[qi] + $urandom_range(0, (qi == QImu) ? 3000 : 12000);
        send_item(push_kind[qi], stamp[qi], HandleBits'($urandom_range(65535)));
        done++;
      end else if (roll < 94) begin
        pop_one();
        done++;
      end else if (roll < 96) begin
        send_item(KindClear, ts, HandleBits'($urandom_range(65535)));
        reseed_stamps();
        done++;
      end else begin
        qi = $urandom_range(2);
        case ($urandom_range(2))
          0: begin
            kind = KindBits'($urandom_range(KindFirstUnused, KindLastUnused));
            send_item(kind, ts, HandleBits'($urandom_range(65535)));
          end
          1: begin
            send_item(push_kind[qi], stamp[qi] - $urandom_range(1, 5000),
                      HandleBits'($urandom_range(65535)));
            done++;
          end
          default: begin
            send_item(push_kind[qi], ts, HandleBits'($urandom_range(65535)));
            done++;
          end
        endcase
      end
    end
  endtask

  task automatic test_empty_queue();
    pop_one();
    send_item(KindFirstUnused, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(KindLastUnused, 32'h0, 16'h0);
    send_item(KindClear, 32'h0, 16'h0);
  endtask

  task automatic test_push_order();
    send_item(KindPushImu, 32'd1000, 16'h0000);
    send_item(KindPushImu, 32'd1000, 16'hFFFF);
    send_item(KindPushImu, 32'd999, 16'h1234);
    pop_one();
    pop_one();
    pop_one();
    send_item(KindPushImu, 32'hFFFF_FFFF, 16'hA5A5);
    send_item(KindPushImu, 32'h0, 16'h5A5A);
    send_item(KindClear, 32'h0, 16'h0);
    send_item(KindPushImu, 32'h0, 16'h0001);
    send_item(KindClear, 32'h0, 16'h0);
  endtask

  task automatic test_pick_rules();
    send_item(KindPushImu, 32'd500, 16'h0011);
    send_item(KindPushLeft, 32'd500, 16'h0022);
    pop_one();
    pop_one();
    send_item(KindPushImu, 32'd499, 16'h0033);
    send_item(KindPushRight, 32'd500, 16'h0044);
    pop_one();
    pop_one();
    send_item(KindPushImu, 32'd700, 16'h0055);
    send_item(KindPushLeft, 32'd600, 16'h0066);
    send_item(KindPushRight, 32'd800, 16'h0077);
    send_item(KindPushImu, 32'd900, 16'h0088);
    pop_one();
    pop_one();
    pop_one();
    send_item(KindPushLeft, 32'd10000, 16'h0099);
    send_item(KindPushRight, 32'd20000, 16'h00AA);
    pop_one();
    pop_one();
    set_tolerance(32'd0);
    send_item(KindPushLeft, 32'd30000, 16'h00BB);
    send_item(KindPushRight, 32'd30000, 16'h00CC);
    pop_one();
    pop_one();
    set_tolerance(32'd1);
    send_item(KindPushLeft, 32'd40000, 16'h00DD);
    send_item(KindPushRight, 32'd40000, 16'h00EE);
    pop_one();
    set_tolerance(32'hFFFF_FFFF);
    send_item(KindClear, 32'h0, 16'h0);
    send_item(KindPushLeft, 32'h0, 16'hF0F0);
    send_item(KindPushRight, 32'hFFFF_FFFF, 16'h0F0F);
    pop_one();
    pop_one();
  endtask

  task automatic test_queue_full();
    int i;
    set_tolerance(ToleranceReset);
    send_item(KindClear, 32'h0, 16'h0);
    for (i = 0; i < ImageDepth; i++) begin
      send_item(KindPushLeft, 32'd100 + i, 16'(i));
      send_item(KindPushRight, 32'd90 + 2 * i, 16'(i + 100));
    end
    send_item(KindPushLeft, 32'd200, 16'h1111);
    send_item(KindPushLeft, 32'd50, 16'h2222);
    send_item(KindPushRight, 32'd200, 16'h3333);
    send_item(KindPushRight, 32'd50, 16'h4444);
    for (i = 0; i < ImuDepth; i++) begin
      send_item(KindPushImu, 32'd80 + i / 4, HandleBits'($urandom_range(65535)));
    end
    send_item(KindPushImu, 32'd1000, 16'h5555);
    send_item(KindPushImu, 32'd10, 16'h6666);
    repeat (12) pop_one();
    send_item(KindClear, 32'h0, 16'h0);
  endtask

  task automatic test_random_traffic();
    set_tolerance(ToleranceReset);
    idle_pct = 0;
    stall_pct = 0;
    run_random(175);
    set_tolerance(32'd0);
    idle_pct = 63;
    stall_pct = 0;
    run_random(175);
    set_tolerance(32'hFFFF_FFFF);
    idle_pct = 0;
    stall_pct = 63;
    run_random(175);
    set_tolerance($urandom_range(1, 20000));
    idle_pct = 11;
    stall_pct = 11;
    run_random(175);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    hold_cycles = 150;
    run_random(40);
  endtask

  initial begin
    push_kind[QImu] = KindPushImu;
    push_kind[QLeft] = KindPushLeft;
    push_kind[QRight] = KindPushRight;
    tolerance_us = ToleranceReset;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    fail_count = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = KindPushImu;
    req_bus.time_stamp = '0;
    req_bus.payload_handle = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_push_order();
    test_pick_rules();
    test_queue_full();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    if (outcomes_due.size() != 0) begin
      fail_count += outcomes_due.size();
      $display("%0d results never arrived", outcomes_due.size());
    end
    if (fail_count == 0) begin
      $display("tb_imu_stereo_timestamp_merge passed");
    end else begin
      $display("tb_imu_stereo_timestamp_merge failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/istm_pkg.sv
rtl/istm_if.sv
rtl/istm_ram.sv
rtl/istm_pick.sv
rtl/imu_stereo_timestamp_merge.sv
bench/tb_imu_stereo_timestamp_merge.sv
